// ===== hw/rtl/i2cbe_pkg.sv =====
// Shared command codes, reset constant and result beat type for the I2C bit engine.
package i2cbe_pkg;

	localparam logic [2:0] CMD_IDLE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_ACK   = 3'd5;
	localparam logic [2:0] CMD_NACK  = 3'd6;
	localparam logic [2:0] CMD_WAIT  = 3'd7;

	localparam logic [7:0] HALF_PERIOD_RST = 8'd8;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       got_nack;
		logic       rejected;
	} res_t;

endpackage

// ===== hw/rtl/i2cbe_seq.sv =====
// Command sequencer: phase, bit and tick bookkeeping and pin levels.
module i2cbe_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [2:0]       kind,
	input  logic [7:0]       write_byte,
	input  logic             sda_level,
	input  logic [7:0]       half_period,
	output i2cbe_pkg::res_t  res
);

	logic [2:0] cmd_q, cmd_d;
	logic [1:0] phase_q, phase_d;
	logic [2:0] bit_q, bit_d;
	logic [7:0] tick_q, tick_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] tx_q, tx_d;
	logic       nack_q, nack_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       done_d;
	logic       rej_d;
	logic [7:0] hp;
	logic       last_tick;
	logic       last_phase;
	logic       last_bit;

	function automatic logic [1:0] apply_phase(input logic [2:0] c, input logic [1:0] p,
			input logic [2:0] b, input logic [7:0] tx, input logic scl, input logic sda);
		logic s_scl;
		logic s_sda;
		begin
			s_scl = scl;
			s_sda = sda;
			unique case (c)
				i2cbe_pkg::CMD_START: begin
					if (p == 2'd0) begin
						s_sda = 1'b1;
						s_scl = 1'b1;
					end else if (p == 2'd1) begin
						s_sda = 1'b0;
					end else begin
						s_scl = 1'b0;
					end
				end
				i2cbe_pkg::CMD_STOP: begin
					if (p == 2'd0) begin
						s_scl = 1'b0;
						s_sda = 1'b0;
					end else if (p == 2'd1) begin
						s_scl = 1'b1;
					end else begin
						s_sda = 1'b1;
					end
				end
				i2cbe_pkg::CMD_ACK, i2cbe_pkg::CMD_NACK, i2cbe_pkg::CMD_WAIT: begin
					if (p == 2'd0) begin
						s_sda = (c != i2cbe_pkg::CMD_ACK);
					end else if (p == 2'd1) begin
						s_scl = 1'b1;
					end else begin
						s_scl = 1'b0;
					end
				end
				i2cbe_pkg::CMD_WRITE: begin
					if (p == 2'd0) begin
						s_sda = tx[3'd7 - b];
					end else if (p == 2'd1) begin
						s_scl = 1'b1;
					end else begin
						s_scl = 1'b0;
						if (b == 3'd7) begin
							s_sda = 1'b1;
						end
					end
				end
				i2cbe_pkg::CMD_READ: begin
					s_scl = (p == 2'd0);
				end
				default: begin
				end
			endcase
			apply_phase = {s_scl, s_sda};
		end
	endfunction

	assign hp         = (half_period == 8'd0) ? 8'd1 : half_period;
	assign last_tick  = (tick_q >= hp - 8'd1);
	assign last_phase = (cmd_q == i2cbe_pkg::CMD_READ) ? (phase_q >= 2'd1) : (phase_q >= 2'd2);
	assign last_bit   = (cmd_q == i2cbe_pkg::CMD_WRITE || cmd_q == i2cbe_pkg::CMD_READ) ?
		(bit_q == 3'd7) : 1'b1;

	always_comb begin
		cmd_d   = cmd_q;
		phase_d = phase_q;
		bit_d   = bit_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		tx_d    = tx_q;
		nack_d  = nack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		done_d  = 1'b0;
		rej_d   = 1'b0;
		if (cmd_q == i2cbe_pkg::CMD_IDLE) begin
			if (kind != i2cbe_pkg::CMD_IDLE) begin
				cmd_d   = kind;
				phase_d = 2'd0;
				bit_d   = 3'd0;
				tick_d  = 8'd0;
				if (kind == i2cbe_pkg::CMD_WRITE) begin
					tx_d = write_byte;
				end
				if (kind == i2cbe_pkg::CMD_READ) begin
					shift_d = 8'd0;
				end
				{scl_d, sda_d} = apply_phase(kind, 2'd0, 3'd0, tx_d, scl_q, sda_q);
			end
		end else begin
			rej_d = (kind != i2cbe_pkg::CMD_IDLE);
			if (last_tick) begin
				tick_d = 8'd0;
				if (cmd_q == i2cbe_pkg::CMD_WAIT && phase_q == 2'd1) begin
					nack_d = sda_level;
				end
				if (cmd_q == i2cbe_pkg::CMD_READ && phase_q == 2'd0) begin
					shift_d = {shift_q[6:0], sda_level};
				end
				if (last_phase) begin
					phase_d = 2'd0;
					if (last_bit) begin
						if (cmd_q == i2cbe_pkg::CMD_ACK) begin
							sda_d = 1'b1;
						end
						cmd_d  = i2cbe_pkg::CMD_IDLE;
						bit_d  = 3'd0;
						done_d = 1'b1;
					end else begin
						bit_d = bit_q + 3'd1;
						{scl_d, sda_d} = apply_phase(cmd_q, 2'd0, bit_d, tx_q, scl_q, sda_q);
					end
				end else begin
					phase_d = phase_q + 2'd1;
					{scl_d, sda_d} = apply_phase(cmd_q, phase_d, bit_q, tx_q, scl_q, sda_q);
				end
			end else begin
				tick_d = tick_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cbe_pkg::CMD_IDLE;
			phase_q <= 2'd0;
			bit_q   <= 3'd0;
			tick_q  <= 8'd0;
			shift_q <= 8'd0;
			tx_q    <= 8'd0;
			nack_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (acc) begin
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			tx_q    <= tx_d;
			nack_q  <= nack_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
		end
	end

	always_comb begin
		res.scl_drive = scl_d;
		res.sda_drive = sda_d;
		res.busy_res  = (cmd_d != i2cbe_pkg::CMD_IDLE);
		res.done_res  = done_d;
		res.read_byte = shift_d;
		res.got_nack  = nack_d;
		res.rejected  = rej_d;
	end

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_d |-> (cmd_q != i2cbe_pkg::CMD_IDLE))
		else $error("done without an active command");

	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd_q == i2cbe_pkg::CMD_IDLE && kind != i2cbe_pkg::CMD_IDLE)
		|=> (cmd_q != i2cbe_pkg::CMD_IDLE))
		else $error("command did not start");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q == i2cbe_pkg::CMD_IDLE) |-> (phase_q == 2'd0 && bit_q == 3'd0 && tick_q == 8'd0))
		else $error("counters not cleared while idle");

	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rej_d |-> (cmd_q != i2cbe_pkg::CMD_IDLE))
		else $error("reject while idle");

endmodule

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: config register, sequencer, result buffering.
// A result beat goes into the result register, or into the skid entry while out_stall holds the result register.
// Throughput: one input beat per cycle while in_stall is low; the sequencer state updates in a single pass.
// A two-entry output buffer (result register plus skid) absorbs one input beat while out_stall holds the result.
// Reset: arst_n clears the sequencer to idle with SCL and SDA released and half period 8 ticks.
// Input stalls only while the skid entry holds a beat.
module i2c_master_bit_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic [7:0] write_byte,
	input  logic       sda_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_drive,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_byte,
	output logic       got_nack,
	output logic       rejected
);

	logic [7:0]      half_period_q;
	logic            acc;
	logic            pop;
	i2cbe_pkg::res_t res;
	i2cbe_pkg::res_t out_q;
	i2cbe_pkg::res_t skid_q;
	logic            out_valid_q;
	logic            skid_valid_q;

	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !in_stall;
	assign pop      = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cbe_pkg::HALF_PERIOD_RST;
		end else if (cfg_wen) begin
			half_period_q <= cfg_wdata;
		end
	end

	i2cbe_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.kind        (kind),
		.write_byte  (write_byte),
		.sda_level   (sda_level),
		.half_period (half_period_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (!out_valid_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign scl_drive = out_q.scl_drive;
	assign sda_drive = out_q.sda_drive;
	assign busy_res  = out_q.busy_res;
	assign done_res  = out_q.done_res;
	assign read_byte = out_q.read_byte;
	assign got_nack  = out_q.got_nack;
	assign rejected  = out_q.rejected;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat with the result register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(acc && out_valid_q && out_stall))
		else $error("skid filled without a stalled result");

	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(pop && !acc))
		else $error("result beat dropped without being taken");

endmodule
